@@ sv/pidfd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the filtered-derivative PID core.
package pidfd_pkg;

    localparam int SIG_W  = 16;
    localparam int TERM_W = 32;
    localparam int STAMP_W = 32;
    localparam int CFG_IDX_W = 3;

    // Shortest elapsed interval, in ticks, that yields a new output.
    localparam logic [15:0] MIN_INTERVAL_TICKS = 16'd1;
    localparam logic [15:0] DT_CAP = 16'hFFFF;

    localparam logic [SIG_W-1:0] LIM_MAX_RST = 16'h7FFF;
    localparam logic [SIG_W-1:0] LIM_MIN_RST = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_FILTER_TAU = 3'd3,
        CFG_OUT_MAX    = 3'd4,
        CFG_OUT_MIN    = 3'd5,
        CFG_INTEG_MAX  = 3'd6,
        CFG_INTEG_MIN  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SIG_W-1:0] target;
        logic signed [SIG_W-1:0] sensed;
        logic [STAMP_W-1:0]      stamp;
    } t_in;

    typedef struct packed {
        logic signed [SIG_W-1:0]  drive;
        logic                     updated;
        logic signed [TERM_W-1:0] p_part;
        logic signed [TERM_W-1:0] i_part;
        logic signed [TERM_W-1:0] d_part;
    } t_out;

endpackage

@@ sv/pid_controller_filtered_derivative_core.sv @@
`timescale 1ns / 1ps
// Top level: sequenced PID core with one shared multiplier and a radix-4 divider.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  input    | i_in_valid / o_in_ready   | i_in_data  (t_in: target, sensed, stamp)
//  output   | o_out_valid / i_out_ready | o_out_data (t_out: drive, updated, terms)
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data (no wait, no read-back)
//
// Sequence: a computed sample steps through S_DT, S_MP to S_MF, S_NUM, S_DIV,
//   S_DFIN, S_SUM and S_DONE before o_out_valid rises, and o_in_ready returns
//   with it; a repeated output (first sample, too short an interval) goes from
//   S_DT straight to S_DONE. The restoring divide (2 quotient bits per cycle)
//   for the derivative dominates; five products go one per cycle through the
//   shared 32x18 multiplier.
// One sample is in flight at a time; o_in_ready is high only while idle.
// Reset (synchronous, active low) clears the controller state and loads the
//   register defaults; a stalled output holds the sequencer in its last step.
module pid_controller_filtered_derivative_core
    import pidfd_pkg::*;
#(
    parameter logic [15:0] MIN_INTERVAL = MIN_INTERVAL_TICKS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample in
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    // result out
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    // register writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIG_W-1:0]     i_cfg_data
);

    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;   // 50
    localparam int ISUM_W   = PROD_W + 1;          // integral before clamp
    localparam int NUM_W    = 50;                  // derivative numerator
    localparam int DEN_W    = 18;
    localparam int DIV_STEPS = NUM_W / 2;          // 2 bits per cycle
    localparam int CNT_W    = $clog2(DIV_STEPS);
    localparam int U_W      = TERM_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_DT, S_MP, S_MKI, S_MI, S_MD, S_MF,
        S_NUM, S_DIV, S_DFIN, S_SUM, S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic signed [SIG_W-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [SIG_W-1:0]        r_filter_tau;
    logic signed [SIG_W-1:0] r_out_max, r_out_min, r_integ_max, r_integ_min;

    // controller state
    logic                     r_primed;
    logic [STAMP_W-1:0]       r_last_stamp;
    logic signed [TERM_W-1:0] r_integ_acc, r_deriv_acc, r_prop_acc;
    logic signed [SIG_W:0]    r_prev_err;
    logic signed [SIG_W-1:0]  r_prev_sensed;
    logic signed [SIG_W-1:0]  r_last_drive;

    // working registers for one sample
    t_in                      r_in;
    logic                     r_upd;
    logic [15:0]              r_dt;
    logic signed [SIG_W:0]    r_e;
    logic signed [SIG_W:0]    r_ds;
    logic signed [SIG_W+1:0]  r_esum;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [TERM_W-1:0] r_p, r_i, r_d;
    logic signed [ISUM_W-1:0] r_isum;
    logic signed [32:0]       r_t1;
    logic                     r_num_neg;
    logic [DEN_W-1:0]         r_den;
    logic [DEN_W-1:0]         r_rem;
    logic [NUM_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [U_W-1:0]    r_u;

    t_out r_out;
    logic r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- elapsed time and differences ----------------
    logic [STAMP_W-1:0]      n_el;
    logic [15:0]             n_dt;
    logic                    n_short;
    always_comb begin
        n_el    = r_in.stamp - r_last_stamp;
        n_dt    = (|n_el[31:16]) ? DT_CAP : n_el[15:0];
        n_short = (n_dt == 16'd0) || (n_dt < MIN_INTERVAL);
    end

    // 2*tau -/+ dt
    logic [DEN_W-1:0]        n_tau2;
    logic signed [DEN_W-1:0] n_tdiff;
    logic [DEN_W-1:0]        n_den;
    always_comb begin
        n_tau2  = {1'b0, r_filter_tau, 1'b0};
        n_tdiff = $signed(n_tau2 - {2'b00, r_dt});
        n_den   = n_tau2 + {2'b00, r_dt};
    end

    // ---------------- shared multiplier ----------------
    logic signed [MUL_A_W-1:0] n_ma;
    logic signed [MUL_B_W-1:0] n_mb;
    logic signed [PROD_W-1:0]  n_prod;
    always_comb begin
        unique case (r_state)
            S_MP: begin   // Kp * e
                n_ma = MUL_A_W'(r_e);
                n_mb = MUL_B_W'(r_prop_gain);
            end
            S_MKI: begin  // Ki * dt
                n_ma = {16'd0, r_dt};
                n_mb = MUL_B_W'(r_integ_gain);
            end
            S_MI: begin   // (Ki*dt) * (e + prev_err)
                n_ma = r_prod[MUL_A_W-1:0];
                n_mb = r_esum;
            end
            S_MD: begin   // Kd * (sensed - prev_sensed)
                n_ma = MUL_A_W'(r_ds);
                n_mb = MUL_B_W'(r_deriv_gain);
            end
            S_MF: begin   // (2*tau - dt) * deriv_acc
                n_ma = r_deriv_acc;
                n_mb = n_tdiff;
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
        n_prod = n_ma * n_mb;
    end

    // ---------------- integral clamp ----------------
    logic signed [ISUM_W-1:0] n_ihi, n_ilo;
    logic signed [TERM_W-1:0] n_iclamp;
    always_comb begin
        n_ihi = {{(ISUM_W-SIG_W-8){r_integ_max[SIG_W-1]}}, r_integ_max, 8'h00};
        n_ilo = {{(ISUM_W-SIG_W-8){r_integ_min[SIG_W-1]}}, r_integ_min, 8'h00};
        priority if (r_isum > n_ihi) begin
            n_iclamp = n_ihi[TERM_W-1:0];
        end else if (r_isum < n_ilo) begin
            n_iclamp = n_ilo[TERM_W-1:0];
        end else begin
            n_iclamp = r_isum[TERM_W-1:0];
        end
    end

    // ---------------- derivative numerator ----------------
    logic signed [NUM_W-1:0] n_num;
    logic [NUM_W-1:0]        n_mag;
    always_comb begin
        n_num = {{(NUM_W-34){r_t1[32]}}, r_t1, 1'b0} + r_prod;
        n_mag = n_num[NUM_W-1] ? NUM_W'(-n_num) : n_num;
    end

    // ---------------- divider: two restoring steps ----------------
    logic [DEN_W:0]   n_rem1, n_rem2;
    logic             n_ge1, n_ge2;
    logic [DEN_W-1:0] n_rem1r, n_rem2r;
    logic [NUM_W-1:0] n_quo;
    always_comb begin
        n_rem1  = {r_rem, r_quo[NUM_W-1]};
        n_ge1   = (n_rem1 >= {1'b0, r_den});
        n_rem1r = n_ge1 ? DEN_W'(n_rem1 - {1'b0, r_den}) : n_rem1[DEN_W-1:0];
        n_rem2  = {n_rem1r, r_quo[NUM_W-2]};
        n_ge2   = (n_rem2 >= {1'b0, r_den});
        n_rem2r = n_ge2 ? DEN_W'(n_rem2 - {1'b0, r_den}) : n_rem2[DEN_W-1:0];
        n_quo   = {r_quo[NUM_W-3:0], n_ge1, n_ge2};
    end

    // ---------------- derivative saturation ----------------
    // d = -trunc(num/den); r_quo holds |num|/den.
    logic signed [TERM_W-1:0] n_dsat;
    always_comb begin
        if (r_num_neg) begin
            n_dsat = (r_quo > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                   : $signed(r_quo[TERM_W-1:0]);
        end else begin
            n_dsat = (r_quo > NUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                   : $signed(-r_quo[TERM_W-1:0]);
        end
    end

    // ---------------- output clamp ----------------
    logic signed [U_W-1:0]   n_ohi, n_olo;
    logic signed [SIG_W-1:0] n_drive;
    always_comb begin
        n_ohi = {{(U_W-SIG_W-8){r_out_max[SIG_W-1]}}, r_out_max, 8'h00};
        n_olo = {{(U_W-SIG_W-8){r_out_min[SIG_W-1]}}, r_out_min, 8'h00};
        priority if (r_u > n_ohi) begin
            n_drive = r_out_max;
        end else if (r_u < n_olo) begin
            n_drive = r_out_min;
        end else begin
            n_drive = r_u[SIG_W+7:8];   // floor(u / 256)
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_filter_tau  <= '0;
            r_out_max     <= LIM_MAX_RST;
            r_out_min     <= LIM_MIN_RST;
            r_integ_max   <= LIM_MAX_RST;
            r_integ_min   <= LIM_MIN_RST;
            r_primed      <= 1'b0;
            r_last_stamp  <= '0;
            r_integ_acc   <= '0;
            r_deriv_acc   <= '0;
            r_prop_acc    <= '0;
            r_prev_err    <= '0;
            r_prev_sensed <= '0;
            r_last_drive  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                    CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                    CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                    CFG_FILTER_TAU: r_filter_tau <= i_cfg_data;
                    CFG_OUT_MAX:    r_out_max    <= i_cfg_data;
                    CFG_OUT_MIN:    r_out_min    <= i_cfg_data;
                    CFG_INTEG_MAX:  r_integ_max  <= i_cfg_data;
                    CFG_INTEG_MIN:  r_integ_min  <= i_cfg_data;
                    default: ;
                endcase
            end

            // the done step handles its own output transfer
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_DT;
                    end
                end
                S_DT: begin
                    r_dt   <= n_dt;
                    r_e    <= (SIG_W+1)'(r_in.target) - (SIG_W+1)'(r_in.sensed);
                    r_ds   <= (SIG_W+1)'(r_in.sensed) - (SIG_W+1)'(r_prev_sensed);
                    r_esum <= (SIG_W+2)'(r_in.target) - (SIG_W+2)'(r_in.sensed)
                              + (SIG_W+2)'(r_prev_err);
                    if (!r_primed) begin
                        // first sample only sets the time base
                        r_primed     <= 1'b1;
                        r_last_stamp <= r_in.stamp;
                        r_upd        <= 1'b0;
                        r_state      <= S_DONE;
                    end else if (n_short) begin
                        r_upd   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_upd   <= 1'b1;
                        r_state <= S_MP;
                    end
                end
                S_MP: begin
                    r_prod  <= n_prod;
                    r_state <= S_MKI;
                end
                S_MKI: begin
                    r_p     <= r_prod[TERM_W-1:0];
                    r_prod  <= n_prod;
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_prod  <= n_prod;
                    r_state <= S_MD;
                end
                S_MD: begin
                    // trapezoid: floor(product / 2) added to the integrator
                    r_isum  <= {{(ISUM_W-TERM_W){r_integ_acc[TERM_W-1]}}, r_integ_acc}
                               + {{2{r_prod[PROD_W-1]}}, r_prod[PROD_W-1:1]};
                    r_prod  <= n_prod;
                    r_state <= S_MF;
                end
                S_MF: begin
                    r_t1    <= r_prod[32:0];
                    r_i     <= n_iclamp;
                    r_prod  <= n_prod;
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num_neg <= n_num[NUM_W-1];
                    r_quo     <= n_mag;
                    r_rem     <= '0;
                    r_den     <= n_den;
                    r_cnt     <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem2r;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    r_d     <= n_dsat;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_u     <= U_W'(r_p) + U_W'(r_i) + U_W'(r_d);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_upd) begin
                            r_prop_acc    <= r_p;
                            r_integ_acc   <= r_i;
                            r_deriv_acc   <= r_d;
                            r_prev_err    <= r_e;
                            r_prev_sensed <= r_in.sensed;
                            r_last_drive  <= n_drive;
                            r_last_stamp  <= r_in.stamp;
                            r_out.drive   <= n_drive;
                            r_out.updated <= 1'b1;
                            r_out.p_part  <= r_p;
                            r_out.i_part  <= r_i;
                            r_out.d_part  <= r_d;
                        end else begin
                            r_out.drive   <= r_last_drive;
                            r_out.updated <= 1'b0;
                            r_out.p_part  <= r_prop_acc;
                            r_out.i_part  <= r_integ_acc;
                            r_out.d_part  <= r_deriv_acc;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the filtered-derivative PID core, with its own predictor.
module tb;
    import pidfd_pkg::*;

    localparam int  SETTLE      = 8;     // cycles for the sequencer to return to idle
    localparam int  TAIL        = 40;    // drain time after the last result
    localparam int  STALL_LIMIT = 2000;  // cycles without any transfer before giving up
    localparam int  RAND_ITEMS  = 1930;  // samples sent by the random part
    localparam longint TERM_HI  = 64'sd2147483647;
    localparam longint TERM_LO  = -64'sd2147483648;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    // One line of the directed table: a register write or a sample, the sample
    // optionally carrying a hand-computed drive and updated flag.
    typedef struct packed {
        t_row_kind               kind;
        t_cfg_idx                sel;
        logic [SIG_W-1:0]        val;
        t_in                     smp;
        logic                    pin;
        logic signed [SIG_W-1:0] pin_drive;
        logic                    pin_upd;
    } t_dir_row;

    localparam int DIR_ROWS = 44;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        // first sample only sets the time base, then a zero interval
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sd0, 32'd100}, 1'b1, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd5, 16'sd3, 32'd100}, 1'b1, 16'sd0, 1'b0},
        // all gains zero after reset
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd5, 16'sd3, 32'd101}, 1'b1, 16'sd0, 1'b1},
        '{ROW_WRITE,  CFG_PROP_GAIN,  16'h0100, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_GAIN, 16'h0010, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_DERIV_GAIN, 16'h0200, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_FILTER_TAU, 16'h0000, '0, 1'b0, 16'sd0, 1'b0},
        // full-scale error both ways pins the output at the limits, then a repeat
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sh7FFF, 16'sh8000, 32'd111},
          1'b1, 16'sh7FFF, 1'b1},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sh8000, 16'sh7FFF, 32'd112},
          1'b1, 16'sh8000, 1'b1},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sd0, 32'd112},
          1'b1, 16'sh8000, 1'b0},
        // extreme gains and time constant; stamp behind, stamp wrap
        '{ROW_WRITE,  CFG_FILTER_TAU, 16'hFFFF, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_PROP_GAIN,  16'h7FFF, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_GAIN, 16'h8000, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_DERIV_GAIN, 16'h7FFF, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd1000, -16'sd1000, 32'hFFFF_FFF0},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{-16'sd1000, 16'sd1000, 32'h0000_0005},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sd0, 32'h0000_0004},
          1'b0, 16'sd0, 1'b0},
        // narrow output and integrator limits
        '{ROW_WRITE,  CFG_OUT_MAX,    16'h0064, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_OUT_MIN,    16'hFF9C, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_MAX,  16'h0032, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_MIN,  16'hFFCE, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd200, 16'sd0, 32'h0000_0010},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{-16'sd200, 16'sd0, 32'h0000_0020},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sd0, 32'h0001_0020},
          1'b0, 16'sd0, 1'b0},
        // crossed limits: the max test wins
        '{ROW_WRITE,  CFG_OUT_MAX,    16'hFFF6, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_OUT_MIN,    16'h000A, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_MAX,  16'hFFEC, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_MIN,  16'h0014, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd100, 16'sd0, 32'h0001_0030},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{-16'sd100, 16'sd0, 32'h0001_0031},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sd0, 32'h0001_0040},
          1'b0, 16'sd0, 1'b0},
        // derivative alone, tau zero: a full-scale step saturates the term
        '{ROW_WRITE,  CFG_PROP_GAIN,  16'h0000, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_GAIN, 16'h0000, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_DERIV_GAIN, 16'h8000, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_FILTER_TAU, 16'h0000, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_OUT_MAX,    16'h7FFF, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_OUT_MIN,    16'h8000, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_MAX,  16'h7FFF, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE,  CFG_INTEG_MIN,  16'h8000, '0, 1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sh8000, 32'h0002_0000},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sh7FFF, 32'h0002_0001},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sh8000, 32'h0002_0002},
          1'b0, 16'sd0, 1'b0},
        // largest stamp, then wrap to zero (one tick)
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sd0, 32'hFFFF_FFFF},
          1'b0, 16'sd0, 1'b0},
        '{ROW_SAMPLE, CFG_PROP_GAIN,  16'h0000, '{16'sd0, 16'sd0, 32'h0000_0000},
          1'b0, 16'sd0, 1'b0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out                 o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SIG_W-1:0]     i_cfg_data;

    pid_controller_filtered_derivative_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state, mirrors the controller after each transfer in.
    logic [SIG_W-1:0]          cfg_regs [8];
    bit                        have_time;
    logic [STAMP_W-1:0]        time_ref;
    logic signed [TERM_W-1:0]  integ_term;
    logic signed [TERM_W-1:0]  deriv_term;
    logic signed [TERM_W-1:0]  prop_term;
    logic signed [SIG_W:0]     err_prev;
    logic signed [SIG_W-1:0]   sensed_prev;
    logic signed [SIG_W-1:0]   drive_last;

    t_out pending_ctl [$];   // expected results, oldest first
    int   err_cnt     = 0;
    int   idle_cycles = 0;
    bit   calm        = 1'b0; // phase without gaps or stalls

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint floor_by(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q -= 1;
        return q;
    endfunction

    // Computes the result of one sample and advances the controller state.
    function automatic t_out predict_control(input t_in smp);
        longint tgt, sen, dt, e, p, ig, d, num, den, u, drv;
        longint kp, ki, kd, tau, ohi, olo, ihi, ilo;
        logic [STAMP_W-1:0] span;
        t_out r;
        r.drive   = drive_last;
        r.updated = 1'b0;
        r.p_part  = prop_term;
        r.i_part  = integ_term;
        r.d_part  = deriv_term;
        if (!have_time) begin
            have_time = 1'b1;
            time_ref  = smp.stamp;
            return r;
        end
        span = smp.stamp - time_ref;
        dt   = (span > STAMP_W'(DT_CAP)) ? longint'(DT_CAP) : longint'(span);
        if (dt == 0 || dt < longint'(MIN_INTERVAL_TICKS)) return r;

        kp  = $signed(cfg_regs[CFG_PROP_GAIN]);
        ki  = $signed(cfg_regs[CFG_INTEG_GAIN]);
        kd  = $signed(cfg_regs[CFG_DERIV_GAIN]);
        tau = cfg_regs[CFG_FILTER_TAU];
        ohi = $signed(cfg_regs[CFG_OUT_MAX]);
        olo = $signed(cfg_regs[CFG_OUT_MIN]);
        ihi = $signed(cfg_regs[CFG_INTEG_MAX]);
        ilo = $signed(cfg_regs[CFG_INTEG_MIN]);
        tgt = $signed(smp.target);
        sen = $signed(smp.sensed);

        e = tgt - sen;
        p = kp * e;

        // trapezoid, then clamp; the upper bound is tested first
        ig = longint'(integ_term) + floor_by(ki * dt * (e + longint'(err_prev)), 2);
        if (ig > ihi * 256) ig = ihi * 256;
        else if (ig < ilo * 256) ig = ilo * 256;

        // filtered derivative on the measurement, truncating divide
        num = 2 * kd * (sen - longint'(sensed_prev)) + (2 * tau - dt) * longint'(deriv_term);
        den = 2 * tau + dt;
        d   = -(num / den);
        if (d > TERM_HI) d = TERM_HI;
        else if (d < TERM_LO) d = TERM_LO;

        u = p + ig + d;
        if (u > ohi * 256) drv = ohi;
        else if (u < olo * 256) drv = olo;
        else drv = floor_by(u, 256);

        prop_term   = p[TERM_W-1:0];
        integ_term  = ig[TERM_W-1:0];
        deriv_term  = d[TERM_W-1:0];
        err_prev    = e[SIG_W:0];
        sensed_prev = sen[SIG_W-1:0];
        drive_last  = drv[SIG_W-1:0];
        time_ref    = smp.stamp;

        r.drive   = drive_last;
        r.updated = 1'b1;
        r.p_part  = prop_term;
        r.i_part  = integ_term;
        r.d_part  = deriv_term;
        return r;
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    task automatic check_field(input string fld, input logic signed [TERM_W:0] want,
                               input logic signed [TERM_W:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", fld, want, got);
            err_cnt++;
        end
    endtask

    // Called at a rising edge; the register takes the value at the next one.
    task automatic write_reg(input t_cfg_idx sel, input logic [SIG_W-1:0] val,
                             input bit close_we);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= val;
        cfg_regs[sel] = val;
        @(posedge i_clk);
        if (close_we) i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input t_in smp, input bit pin,
                               input logic signed [SIG_W-1:0] pin_drive,
                               input logic pin_upd);
        t_out want;
        int   gap;
        gap = pause_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        want = predict_control(smp);
        if (pin) begin
            want.drive   = pin_drive;
            want.updated = pin_upd;
        end
        pending_ctl.push_back(want);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_ctl.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : out_stall
        int span;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            span = pause_len();
            if (span > 0) begin
                i_out_ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_ctl.size() == 0) begin
                $error("result transfer with nothing outstanding");
                err_cnt++;
            end else begin
                want = pending_ctl.pop_front();
                check_field("drive", want.drive, o_out_data.drive);
                check_field("updated", {1'b0, want.updated}, {1'b0, o_out_data.updated});
                check_field("p_part", want.p_part, o_out_data.p_part);
                check_field("i_part", want.i_part, o_out_data.i_part);
                check_field("d_part", want.d_part, o_out_data.d_part);
            end
        end
    end

    // Ends a hung run: no transfer on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("pid_controller_filtered_derivative_core regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [SIG_W-1:0]   vals [8];
        logic [SIG_W-1:0]   corner [5];
        logic [SIG_W-1:0]   aim, noise, tmp;
        logic [STAMP_W-1:0] now_t;
        t_in                smp;
        bit                 busy;
        int                 sent, prof, v, n, r;

        corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_PROP_GAIN;
        i_cfg_data = '0;

        cfg_regs[CFG_PROP_GAIN]  = '0;
        cfg_regs[CFG_INTEG_GAIN] = '0;
        cfg_regs[CFG_DERIV_GAIN] = '0;
        cfg_regs[CFG_FILTER_TAU] = '0;
        cfg_regs[CFG_OUT_MAX]    = LIM_MAX_RST;
        cfg_regs[CFG_OUT_MIN]    = LIM_MIN_RST;
        cfg_regs[CFG_INTEG_MAX]  = LIM_MAX_RST;
        cfg_regs[CFG_INTEG_MIN]  = LIM_MIN_RST;
        have_time   = 1'b0;
        time_ref    = '0;
        integ_term  = '0;
        deriv_term  = '0;
        prop_term   = '0;
        err_prev    = '0;
        sensed_prev = '0;
        drive_last  = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; writes wait for the core to go idle
        busy = 1'b0;
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (DIR_TAB[k].kind == ROW_WRITE) begin
                if (busy) drain();
                busy = 1'b0;
                write_reg(DIR_TAB[k].sel, DIR_TAB[k].val,
                          k == DIR_ROWS - 1 || DIR_TAB[k + 1].kind != ROW_WRITE);
            end else begin
                send_sample(DIR_TAB[k].smp, DIR_TAB[k].pin, DIR_TAB[k].pin_drive,
                            DIR_TAB[k].pin_upd);
                busy = 1'b1;
            end
        end

        // random phases, each with a fresh register set
        sent = 0;
        while (sent < RAND_ITEMS) begin
            drain();
            prof = $urandom_range(0, 9);
            for (int k = 0; k < 8; k++) vals[k] = SIG_W'($urandom);
            if (prof < 6 || prof == 9) begin
                v = int'($urandom_range(0, 2048)) - 1024;
                vals[CFG_PROP_GAIN] = v[SIG_W-1:0];
                v = int'($urandom_range(0, 128)) - 64;
                vals[CFG_INTEG_GAIN] = v[SIG_W-1:0];
                v = int'($urandom_range(0, 2048)) - 1024;
                vals[CFG_DERIV_GAIN] = v[SIG_W-1:0];
                vals[CFG_FILTER_TAU] = SIG_W'($urandom_range(0, 300));
                v = $urandom_range(0, 32767);
                vals[CFG_OUT_MAX] = v[SIG_W-1:0];
                v = -int'($urandom_range(0, 32768));
                vals[CFG_OUT_MIN] = v[SIG_W-1:0];
                v = $urandom_range(0, 32767);
                vals[CFG_INTEG_MAX] = v[SIG_W-1:0];
                v = -int'($urandom_range(0, 32768));
                vals[CFG_INTEG_MIN] = v[SIG_W-1:0];
                if (prof == 9) begin
                    // crossed limits
                    tmp = vals[CFG_OUT_MAX];
                    vals[CFG_OUT_MAX] = vals[CFG_OUT_MIN];
                    vals[CFG_OUT_MIN] = tmp;
                    tmp = vals[CFG_INTEG_MAX];
                    vals[CFG_INTEG_MAX] = vals[CFG_INTEG_MIN];
                    vals[CFG_INTEG_MIN] = tmp;
                end
            end else if (prof == 8) begin
                for (int k = 0; k < 8; k++) vals[k] = corner[$urandom_range(0, 4)];
            end
            for (int k = 0; k < 8; k++) write_reg(t_cfg_idx'(k), vals[k], k == 7);

            calm  = ($urandom_range(0, 5) == 0);
            aim   = SIG_W'($urandom);
            now_t = $urandom;
            n     = $urandom_range(30, 150);
            for (int k = 0; k < n && sent < RAND_ITEMS; k++) begin
                if ($urandom_range(0, 19) == 0) aim = SIG_W'($urandom);
                if ($urandom_range(0, 4) == 0) begin
                    smp.target = SIG_W'($urandom);
                    smp.sensed = SIG_W'($urandom);
                end else begin
                    noise      = SIG_W'($urandom_range(0, 400));
                    smp.target = aim;
                    smp.sensed = aim + noise - 16'd200;
                end
                // mostly short forward steps; some repeats, long gaps, backward and random jumps
                r = $urandom_range(0, 99);
                if (r < 70) now_t = now_t + $urandom_range(1, 50);
                else if (r < 87 && r >= 80) now_t = now_t + $urandom_range(51, 140000);
                else if (r < 93 && r >= 87) now_t = now_t - $urandom_range(1, 1000);
                else if (r >= 93) now_t = $urandom;
                smp.stamp = now_t;
                send_sample(smp, 1'b0, '0, 1'b0);
                sent++;
            end
        end

        calm = 1'b0;
        drain();
        repeat (TAIL) @(posedge i_clk);
        if (err_cnt == 0 && pending_ctl.size() == 0)
            $display("pid_controller_filtered_derivative_core regression: pass");
        else
            $display("pid_controller_filtered_derivative_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
sv/pidfd_pkg.sv
sv/pid_controller_filtered_derivative_core.sv
tb/tb.sv
